FILE: hw/rtl/rlns_pkg.sv
// Shared types and constants for the radius-limited neighbor sort block.
`timescale 1ns / 1ps
package rlns_pkg;

  // Field widths that are fixed by the request and result formats.
  localparam int IDX_OUT_W   = 5;
  localparam int IN_COORD_W  = 16;
  localparam int CNT_W       = 6;
  localparam int DIST_W      = 33;
  localparam int MAX_RESULTS = 31;
  localparam int RES_CNT_W   = 5;

  // Configuration port geometry: two registers on an 8-byte stride.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;

  localparam logic [DIST_W-1:0] DIST_MAX        = '1;
  localparam logic [CNT_W-1:0]  ROBOT_COUNT_RST = 6'd32;
  localparam logic [DIST_W-1:0] RADIUS_SQ_RST   = 33'd16000000;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_kind_t;

  // Register select, taken from address bit 3.
  typedef enum logic {
    REG_ROBOT_COUNT = 1'b0,
    REG_RADIUS_SQ   = 1'b1
  } reg_sel_t;

  // One decoded request as it sits in the command queue.
  typedef struct packed {
    req_kind_t              kind;
    logic [IDX_OUT_W-1:0]   index;
    logic [IN_COORD_W-1:0]  pos_x;
    logic [IN_COORD_W-1:0]  pos_y;
  } cmd_t;

  // Configuration handed from the register block to the engine.
  typedef struct packed {
    logic [CNT_W-1:0]  robot_count;
    logic [DIST_W-1:0] radius_sq_limit;
  } cfg_t;

endpackage

FILE: hw/rtl/rlns_if.sv
// Request and result channel interfaces with valid/ready handshakes.
`timescale 1ns / 1ps
interface rlns_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [4:0]  agent_index;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, req_type, agent_index, pos_x, pos_y, input ready);
  modport sink   (input valid, req_type, agent_index, pos_x, pos_y, output ready);
endinterface

interface rlns_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  neighbor_index;
  logic        neighbor_valid;
  logic [32:0] neighbor_dist_sq;
  logic        last_of_list;

  modport source (output valid, neighbor_index, neighbor_valid, neighbor_dist_sq,
                  last_of_list, input ready);
  modport sink   (input valid, neighbor_index, neighbor_valid, neighbor_dist_sq,
                  last_of_list, output ready);
endinterface

FILE: hw/rtl/rlns_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rlns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/rlns_front.sv
// Request intake: decodes each request and holds it in a two-entry command queue.
`timescale 1ns / 1ps
module rlns_front (
  input  logic          clk,
  input  logic          rst,
  rlns_req_if.sink      req,
  output rlns_pkg::cmd_t q_head,
  output logic          q_valid,
  input  logic          q_pop
);
  import rlns_pkg::*;

  localparam int QD = 2;

  cmd_t       slots [QD];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  cmd_t       cmd_in;

  // Classify the incoming request.
  always_comb begin
    cmd_in.kind  = req_kind_t'(req.req_type);
    cmd_in.index = req.agent_index;
    cmd_in.pos_x = req.pos_x;
    cmd_in.pos_y = req.pos_y;
  end

  assign req.ready = (fill != 2'(QD));
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_head    = slots[rd_ptr];

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("command popped from an empty queue");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_pop |=> q_valid && $stable(q_head))
    else $error("queue head changed without a pop");

endmodule

FILE: hw/rtl/rlns_back.sv
// Execution engine: position writes, distance sweep, repeated min-selection passes.
`timescale 1ns / 1ps
module rlns_back #(
  parameter int MAX_AGENTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  rlns_pkg::cfg_t cfg,
  input  rlns_pkg::cmd_t q_head,
  input  logic           q_valid,
  output logic           q_pop,
  rlns_rsp_if.source     rsp
);
  import rlns_pkg::*;

  localparam int AW    = $clog2(MAX_AGENTS);
  localparam int CW    = AW + 1;
  localparam int POS_W = 2 * COORD_BITS;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SELF   = 9'b000000010,
    ST_DRD    = 9'b000000100,
    ST_DDIFF  = 9'b000001000,
    ST_DMUL   = 9'b000010000,
    ST_DWR    = 9'b000100000,
    ST_SCAN   = 9'b001000000,
    ST_DECIDE = 9'b010000000,
    ST_FINAL  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [IDX_OUT_W-1:0] cur_self;
  logic [CW-1:0]        cur_count;
  logic [CW-1:0]        cnt_clamp;
  logic                 self_in_tab;
  logic                 head_in_tab;
  logic                 start_query;

  logic [COORD_BITS-1:0] self_x, self_y;
  logic [COORD_BITS-1:0] px, py;
  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       dx2, dy2;
  logic [SUM_W-1:0]      dsum;
  logic [DIST_W-1:0]     dist_sat;
  logic [CW-1:0]         agent;

  logic [CW-1:0]     scan_addr;
  logic              rd_vld;
  logic [AW-1:0]     rd_idx;
  logic              found;
  logic [AW-1:0]     best;
  logic [DIST_W-1:0] best_d;
  logic              cand;
  logic [MAX_AGENTS-1:0] taken;

  logic                 have_pend;
  logic [AW-1:0]        pend_idx;
  logic [DIST_W-1:0]    pend_d;
  logic [RES_CNT_W-1:0] res_cnt;
  logic                 cap_hit;

  logic                 out_free;
  logic                 out_load;
  logic                 out_valid;
  logic [IDX_OUT_W-1:0] out_index;
  logic                 out_nvalid;
  logic [DIST_W-1:0]    out_dist;
  logic                 out_last;

  logic              pos_we;
  logic [AW-1:0]     pos_raddr;
  logic [POS_W-1:0]  pos_wdata;
  logic [POS_W-1:0]  pos_rdata;
  logic [DIST_W-1:0] dist_rdata;

  // Position table and distance buffer.
  rlns_ram #(.WIDTH(POS_W), .DEPTH(MAX_AGENTS)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (AW'(q_head.index)),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  rlns_ram #(.WIDTH(DIST_W), .DEPTH(MAX_AGENTS)) u_dist_ram (
    .clk   (clk),
    .we    (state == ST_DWR),
    .waddr (agent[AW-1:0]),
    .wdata (dist_sat),
    .raddr (scan_addr[AW-1:0]),
    .rdata (dist_rdata)
  );

  // Command decode at the head of the queue.
  assign q_pop       = (state == ST_IDLE) && q_valid;
  assign start_query = q_pop && (q_head.kind == REQ_QUERY);
  assign head_in_tab = (32'(q_head.index) < MAX_AGENTS);
  assign self_in_tab = (32'(cur_self) < MAX_AGENTS);
  assign pos_we      = q_pop && (q_head.kind == REQ_WRITE) && head_in_tab;
  assign pos_wdata   = {COORD_BITS'(q_head.pos_y), COORD_BITS'(q_head.pos_x)};
  assign pos_raddr   = (state == ST_IDLE) ? AW'(q_head.index) : agent[AW-1:0];
  assign cnt_clamp   = (32'(cfg.robot_count) > MAX_AGENTS) ? CW'(MAX_AGENTS)
                                                            : CW'(cfg.robot_count);

  // Distance datapath: difference, square, then sum with saturation.
  assign px       = pos_rdata[COORD_BITS-1:0];
  assign py       = pos_rdata[POS_W-1:COORD_BITS];
  assign dsum     = {1'b0, dx2} + {1'b0, dy2};
  assign dist_sat = (dsum > SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(dsum);

  // Selection compare on the entry read in the previous cycle.
  assign cand = rd_vld && (32'(rd_idx) != 32'(cur_self)) && !taken[rd_idx] &&
                (dist_rdata < cfg.radius_sq_limit) && (!found || dist_rdata <= best_d);

  assign cap_hit  = (res_cnt == RES_CNT_W'(MAX_RESULTS - 1));
  assign out_free = !out_valid || rsp.ready;
  assign out_load = ((state == ST_DECIDE) && out_free && (have_pend || !found)) ||
                    ((state == ST_FINAL) && out_free);

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_query) begin
          state_next = ST_SELF;
        end
      end
      ST_SELF: begin
        state_next = (cur_count == '0) ? ST_SCAN : ST_DRD;
      end
      ST_DRD:   state_next = ST_DDIFF;
      ST_DDIFF: state_next = ST_DMUL;
      ST_DMUL:  state_next = ST_DWR;
      ST_DWR: begin
        state_next = (CW'(agent + 1'b1) == cur_count) ? ST_SCAN : ST_DRD;
      end
      ST_SCAN: begin
        if (scan_addr == cur_count && !rd_vld) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (!found) begin
            state_next = ST_IDLE;
          end else if (cap_hit) begin
            state_next = ST_FINAL;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      taken     <= '0;
      found     <= 1'b0;
      have_pend <= 1'b0;
      res_cnt   <= '0;
      rd_vld    <= 1'b0;
      scan_addr <= '0;
      agent     <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= 1'b0;
      if (start_query) begin
        taken     <= '0;
        have_pend <= 1'b0;
        res_cnt   <= '0;
      end
      if (state == ST_SELF) begin
        agent     <= '0;
        scan_addr <= '0;
        found     <= 1'b0;
      end
      if (state == ST_DWR) begin
        agent <= CW'(agent + 1'b1);
      end
      if (state == ST_SCAN) begin
        if (scan_addr != cur_count) begin
          scan_addr <= CW'(scan_addr + 1'b1);
          rd_vld    <= 1'b1;
        end
        if (cand) begin
          found <= 1'b1;
        end
      end
      if (state == ST_DECIDE && out_free) begin
        found     <= 1'b0;
        scan_addr <= '0;
        if (found) begin
          taken[best] <= 1'b1;
          have_pend   <= 1'b1;
          res_cnt     <= RES_CNT_W'(res_cnt + 1'b1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start_query) begin
      cur_self  <= q_head.index;
      cur_count <= cnt_clamp;
    end
    if (state == ST_SELF) begin
      self_x <= self_in_tab ? px : '0;
      self_y <= self_in_tab ? py : '0;
    end
    if (state == ST_DDIFF) begin
      dx <= (px >= self_x) ? (px - self_x) : (self_x - px);
      dy <= (py >= self_y) ? (py - self_y) : (self_y - py);
    end
    if (state == ST_DMUL) begin
      dx2 <= dx * dx;
      dy2 <= dy * dy;
    end
    rd_idx <= scan_addr[AW-1:0];
    if (state == ST_SCAN && cand) begin
      best   <= rd_idx;
      best_d <= dist_rdata;
    end
    if (state == ST_DECIDE && out_free && found) begin
      pend_idx <= best;
      pend_d   <= best_d;
    end
    if (out_load) begin
      out_index  <= have_pend ? IDX_OUT_W'(pend_idx) : '0;
      out_nvalid <= have_pend;
      out_dist   <= have_pend ? pend_d : '0;
      out_last   <= (state == ST_FINAL) || !found;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.neighbor_index   = out_index;
  assign rsp.neighbor_valid   = out_nvalid;
  assign rsp.neighbor_dist_sq = out_dist;
  assign rsp.last_of_list     = out_last;

  a_in_radius: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.neighbor_valid |-> rsp.neighbor_dist_sq < cfg.radius_sq_limit)
    else $error("listed neighbor lies outside the radius");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.neighbor_valid |-> rsp.last_of_list && rsp.neighbor_dist_sq == '0)
    else $error("empty-list result malformed");

  a_pick_fresh: assert property (@(posedge clk) disable iff (rst)
    state == ST_DECIDE && found |-> !taken[best] && 32'(best) != 32'(cur_self))
    else $error("selection picked the queried agent or a listed one");

endmodule

FILE: hw/rtl/radius_limited_neighbor_sort_core.sv
// Top level: configuration registers, request intake and execution engine.
// Sequence: a write is stored as it leaves the queue. A query reads the queried
// agent's position, sweeps the N agents in use (read, difference, square, write),
// then runs one selection pass per listed neighbor plus a closing pass (a final state
// at a full list). Throughput: one request at a time; the next pops only when idle.
// Reset clears control state and loads register defaults; positions start undefined.
`timescale 1ns / 1ps
module radius_limited_neighbor_sort_core #(
  parameter int MAX_AGENTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  rlns_req_if.sink                        req,
  rlns_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rlns_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rlns_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rlns_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import rlns_pkg::*;

  cfg_t     cfg;
  cmd_t     q_head;
  logic     q_valid;
  logic     q_pop;
  logic     cfg_wr;
  reg_sel_t reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = reg_sel_t'(paddr[3]);

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.robot_count     <= ROBOT_COUNT_RST;
      cfg.radius_sq_limit <= RADIUS_SQ_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_ROBOT_COUNT: cfg.robot_count     <= pwdata[CNT_W-1:0];
        REG_RADIUS_SQ:   cfg.radius_sq_limit <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_sel)
      REG_ROBOT_COUNT: prdata = APB_DATA_W'(cfg.robot_count);
      REG_RADIUS_SQ:   prdata = APB_DATA_W'(cfg.radius_sq_limit);
      default:         prdata = '0;
    endcase
  end

  rlns_front u_front (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  rlns_back #(
    .MAX_AGENTS (MAX_AGENTS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
